@@ hdl/ead_pkg.sv @@
// ----------------------------------------------------------------------------
// Energy activity detector package
// Shared constants, register index codes and fixed-point helper functions
// for the energy based activity detector.
// ----------------------------------------------------------------------------
package ead_pkg;

   // Default build parameters.
   localparam int unsigned INPUT_SHIFT_DEFAULT = 11;
   localparam int unsigned DECIM_BITS_DEFAULT  = 6;

   // Datapath and port widths.
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned SHIFT_W     = 5;
   localparam int unsigned THRESH_W    = 10;
   localparam int unsigned LEVEL_W     = 31;
   localparam int unsigned CSR_DATA_W  = 31;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned PROD_W      = DATA_W + THRESH_W + 1;
   localparam int unsigned NUM_STAGES  = 7;

   // Fixed Q31 limits of the activity and flag accumulators.
   localparam logic [DATA_W-1:0] Q31_0P3  = 32'd644245094;
   localparam logic [DATA_W-1:0] Q31_0P98 = 32'd2104533975;
   localparam logic [DATA_W-1:0] Q31_0P5  = 32'd1073741824;

   // Register reset values.
   localparam logic [SHIFT_W-1:0]  HPF_SHIFT_RESET   = 5'd5;
   localparam logic [SHIFT_W-1:0]  LPF_SHIFT_RESET   = 5'd6;
   localparam logic [SHIFT_W-1:0]  FLOOR_SHIFT_RESET = 5'd10;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET   = 10'd4;
   localparam logic [LEVEL_W-1:0]  FLOOR_MIN_RESET   = 31'd1;
   localparam logic [LEVEL_W-1:0]  ACC_RISE_RESET    = 31'd100000000;
   localparam logic [LEVEL_W-1:0]  ACC_FALL_RESET    = 31'd10000000;
   localparam logic [LEVEL_W-1:0]  ACC_MAX_RESET     = 31'd2147483647;

   // Register index codes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HPF_SHIFT   = 3'd0,
      CSR_LPF_SHIFT   = 3'd1,
      CSR_FLOOR_SHIFT = 3'd2,
      CSR_THRESHOLD   = 3'd3,
      CSR_FLOOR_MIN   = 3'd4,
      CSR_ACC_RISE    = 3'd5,
      CSR_ACC_FALL    = 3'd6,
      CSR_ACC_MAX     = 3'd7
   } csr_index_type;

   // Arithmetic right shift of a 32-bit word.
   function automatic logic [DATA_W-1:0] asr32(input logic [DATA_W-1:0] value,
                                               input logic [SHIFT_W-1:0] amount);
      return DATA_W'($signed(value) >>> amount);
   endfunction

   // One step of the shift-based leaky average: y + (x >> s) - (y >> s).
   function automatic logic [DATA_W-1:0] track32(input logic [DATA_W-1:0] y,
                                                 input logic [DATA_W-1:0] x,
                                                 input logic [SHIFT_W-1:0] s);
      return asr32(x, s) + (y - asr32(y, s));
   endfunction

   // Signed minimum and maximum of two 32-bit words.
   function automatic logic [DATA_W-1:0] smin32(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic logic [DATA_W-1:0] smax32(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
      return ($signed(a) > $signed(b)) ? a : b;
   endfunction

endpackage

@@ hdl/energy_activity_detector.sv @@
// Latency: a transaction accepted into the input register moves through the stages in
// order and shows its result on rsp_valid from the output register (stage 6).
// Throughput: one transaction per cycle while rsp_stall is low; the first-order
// recurrences sit in stages 1, 2, 3, 5 and 6 and each updates as its stage loads.
// Reset: synchronous and active high; it clears all filter state, empties the
// pipeline and loads the register reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Energy activity detector
// Per-sample energy estimate with peak and noise-floor tracking, two activity
// accumulators and a one-bit detection result for every input transaction.
// ----------------------------------------------------------------------------
module energy_activity_detector
   import ead_pkg::*;
#(
   parameter int unsigned INPUT_SHIFT = INPUT_SHIFT_DEFAULT,
   parameter int unsigned DECIM_BITS  = DECIM_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input transactions.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_W-1:0]    req_sample,
   input  logic                   req_block_end,
   // Result transactions.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_detected,
   output logic                   rsp_block_end_out,
   // Configuration writes.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // The chain is a cascade of first-order recurrences, each of which only
   // needs its own previous value and the output of the stage before it.
   // That lets every recurrence live in its own pipeline stage:
   //   stage 0  input register
   //   stage 1  leaky integrator and rectifier
   //   stage 2  energy smoothing filter
   //   stage 3  peak tracker and decimated noise-floor tracker
   //   stage 4  noise floor times threshold
   //   stage 5  activity accumulator
   //   stage 6  flag accumulator and detection (the output register)
   // A stage's state is updated exactly when a transaction enters the stage,
   // so the state sequence matches sample order whatever the stall pattern.

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [SHIFT_W-1:0]  hpf_shift_ff;
   logic [SHIFT_W-1:0]  lpf_shift_ff;
   logic [SHIFT_W-1:0]  floor_shift_ff;
   logic [THRESH_W-1:0] threshold_ff;
   logic [LEVEL_W-1:0]  floor_min_ff;
   logic [LEVEL_W-1:0]  acc_rise_ff;
   logic [LEVEL_W-1:0]  acc_fall_ff;
   logic [LEVEL_W-1:0]  acc_max_ff;

   // Configuration is to be written by the user only while the pipeline is empty
   // (the block does not enforce it), so the registers feed the datapath directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         hpf_shift_ff   <= HPF_SHIFT_RESET;
         lpf_shift_ff   <= LPF_SHIFT_RESET;
         floor_shift_ff <= FLOOR_SHIFT_RESET;
         threshold_ff   <= THRESHOLD_RESET;
         floor_min_ff   <= FLOOR_MIN_RESET;
         acc_rise_ff    <= ACC_RISE_RESET;
         acc_fall_ff    <= ACC_FALL_RESET;
         acc_max_ff     <= ACC_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HPF_SHIFT:   hpf_shift_ff   <= csr_wdata[SHIFT_W-1:0];
            CSR_LPF_SHIFT:   lpf_shift_ff   <= csr_wdata[SHIFT_W-1:0];
            CSR_FLOOR_SHIFT: floor_shift_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_THRESHOLD:   threshold_ff   <= csr_wdata[THRESH_W-1:0];
            CSR_FLOOR_MIN:   floor_min_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_ACC_RISE:    acc_rise_ff    <= csr_wdata[LEVEL_W-1:0];
            CSR_ACC_FALL:    acc_fall_ff    <= csr_wdata[LEVEL_W-1:0];
            CSR_ACC_MAX:     acc_max_ff     <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------------
   // A stage can take a new transaction when it is empty or when its own
   // transaction moves on in the same cycle. Bubbles therefore collapse and
   // the input keeps flowing while a finished result waits, until every stage is full.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;
   logic [NUM_STAGES-1:0] load;
   logic [NUM_STAGES-1:0] block_end_ff;
   logic [NUM_STAGES-1:0] block_end_in;

   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      load[0]         = req_valid && ready[0];
      valid_in[0]     = ready[0] ? req_valid : valid_ff[0];
      block_end_in[0] = load[0] ? req_block_end : block_end_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         load[k]         = valid_ff[k-1] && ready[k];
         valid_in[k]     = ready[k] ? valid_ff[k-1] : valid_ff[k];
         block_end_in[k] = load[k] ? block_end_ff[k-1] : block_end_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The block end marker only travels along with its transaction.
   always_ff @(posedge clock) begin
      block_end_ff <= block_end_in;
   end

   assign req_stall = !ready[0];

   // ------------------------------------------------------------------------
   // Stage 0: input register
   // ------------------------------------------------------------------------
   logic [SAMPLE_W-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         sample_ff <= req_sample;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: leaky integrator difference and rectifier
   // ------------------------------------------------------------------------
   // The difference of the new and old integrator value reduces to
   // x - (integrator >> hpf_shift), so the adder chain stays short.
   logic [DATA_W-1:0] scaled_sample;
   logic [DATA_W-1:0] integ_diff;
   logic [DATA_W-1:0] integrator_ff;
   logic [DATA_W-1:0] integrator_in;
   logic [DATA_W-1:0] rect_ff;
   logic [DATA_W-1:0] rect_in;

   always_comb begin
      scaled_sample = {{(DATA_W - SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff}
                      << INPUT_SHIFT;
      integ_diff    = scaled_sample - asr32(integrator_ff, hpf_shift_ff);
      integrator_in = integrator_ff + integ_diff;
      // The negation of the most negative value wraps back onto itself.
      rect_in       = integ_diff[DATA_W-1] ? (DATA_W'(0) - integ_diff) : integ_diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integrator_ff <= '0;
      end else if (load[1]) begin
         integrator_ff <= integrator_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         rect_ff <= rect_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: energy smoothing filter
   // ------------------------------------------------------------------------
   logic [DATA_W-1:0] energy_ff;
   logic [DATA_W-1:0] energy_in;

   assign energy_in = track32(energy_ff, rect_ff, lpf_shift_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= '0;
      end else if (load[2]) begin
         energy_ff <= energy_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: peak tracker and decimated noise-floor tracker
   // ------------------------------------------------------------------------
   // The decimation counter counts down and wraps; the floor is updated on
   // the transaction that brings it to zero, and the counter then reloads to
   // all ones.
   logic [DATA_W-1:0]     peak_ff;
   logic [DATA_W-1:0]     peak_in;
   logic [DATA_W-1:0]     floor_ff;
   logic [DATA_W-1:0]     floor_in;
   logic [DECIM_BITS-1:0] decim_count_ff;
   logic [DECIM_BITS-1:0] decim_count_in;
   logic [DECIM_BITS-1:0] decim_next;
   logic [DATA_W-1:0]     floor_tracked;

   always_comb begin
      peak_in        = smax32(energy_ff, track32(peak_ff, energy_ff, floor_shift_ff));
      decim_next     = decim_count_ff - DECIM_BITS'(1);
      floor_tracked  = track32(floor_ff, energy_ff, floor_shift_ff);
      floor_in       = floor_ff;
      decim_count_in = decim_next;
      if (decim_next == '0) begin
         floor_in       = smax32({1'b0, floor_min_ff}, smin32(floor_tracked, energy_ff));
         decim_count_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff        <= '0;
         floor_ff       <= '0;
         decim_count_ff <= '0;
      end else if (load[3]) begin
         peak_ff        <= peak_in;
         floor_ff       <= floor_in;
         decim_count_ff <= decim_count_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: detection limit, noise floor times threshold at full width
   // ------------------------------------------------------------------------
   logic signed [PROD_W-1:0] limit_ff;
   logic signed [PROD_W-1:0] limit_in;
   logic [DATA_W-1:0]        peak_cmp_ff;

   assign limit_in = $signed(floor_ff) * $signed({1'b0, threshold_ff});

   always_ff @(posedge clock) begin
      if (load[4]) begin
         limit_ff    <= limit_in;
         peak_cmp_ff <= peak_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: activity accumulator
   // ------------------------------------------------------------------------
   // Sums wrap at 32 bits before the clamp, as the arithmetic is modular.
   logic                signal_above;
   logic [DATA_W-1:0]   activity_up;
   logic [DATA_W-1:0]   activity_down;
   logic [DATA_W-1:0]   activity_ff;
   logic [DATA_W-1:0]   activity_in;

   always_comb begin
      signal_above  = $signed({{(PROD_W - DATA_W){peak_cmp_ff[DATA_W-1]}}, peak_cmp_ff})
                      > limit_ff;
      activity_up   = activity_ff + {1'b0, acc_rise_ff};
      activity_down = activity_ff - {1'b0, acc_fall_ff};
      if (signal_above) begin
         activity_in = smin32({1'b0, acc_max_ff}, activity_up);
      end else begin
         activity_in = activity_down[DATA_W-1] ? '0 : activity_down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         activity_ff <= '0;
      end else if (load[5]) begin
         activity_ff <= activity_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: flag accumulator and detection output register
   // ------------------------------------------------------------------------
   // The roles of the two step sizes swap here: the flag rises by acc_fall
   // and falls by acc_rise, which gives a quick release and slow attack.
   logic [DATA_W-1:0] flag_up;
   logic [DATA_W-1:0] flag_down;
   logic [DATA_W-1:0] flag_ff;
   logic [DATA_W-1:0] flag_in;
   logic              detected_ff;
   logic              detected_in;

   always_comb begin
      flag_up   = flag_ff + {1'b0, acc_fall_ff};
      flag_down = flag_ff - {1'b0, acc_rise_ff};
      if ($signed(activity_ff) > $signed(Q31_0P3)) begin
         flag_in = smin32(Q31_0P98, flag_up);
      end else begin
         flag_in = flag_down[DATA_W-1] ? '0 : flag_down;
      end
      detected_in = $signed(flag_in) > $signed(Q31_0P5);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else if (load[6]) begin
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         detected_ff <= detected_in;
      end
   end

   assign rsp_valid         = valid_ff[NUM_STAGES-1];
   assign rsp_detected      = detected_ff;
   assign rsp_block_end_out = block_end_ff[NUM_STAGES-1];

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // An accepted input transaction always lands in the input stage.
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted transaction missing from input stage");

   // A transaction leaving stage 5 always reaches the output register.
   assert property (@(posedge clock) disable iff (reset)
                    load[NUM_STAGES-1] |=> rsp_valid)
      else $error("transaction lost before the output register");

   // The decimation counter reloads to all ones when a transaction counts it down from one.
   assert property (@(posedge clock) disable iff (reset)
                    (load[3] && decim_count_ff == DECIM_BITS'(1))
                    |=> (decim_count_ff == '1))
      else $error("decimation counter failed to reload");

   // A noise floor update never leaves the floor below its lower limit.
   assert property (@(posedge clock) disable iff (reset)
                    (load[3] && decim_count_ff == DECIM_BITS'(1))
                    |=> ($signed(floor_ff) >= $signed({1'b0, floor_min_ff})))
      else $error("noise floor below its lower limit");
`endif

endmodule
